// File: src/fpfa_pkg.sv
// Shared types and constants of the fixed partition fit allocator.
package fpfa_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;
	localparam logic [15:0] FRAG_MAX  = 16'hFFFF;
	localparam logic [7:0]  PROC_MAX  = 8'hFF;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_ALLOC = 2'd2
	} req_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIT_MODE      = 4'd0,
		CFG_BLOCKS_IN_USE = 4'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  block_slot;
		logic [15:0] request_size;
	} req_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  placed_block;
		logic [15:0] internal_frag;
		logic [7:0]  process_number;
		logic [19:0] total_waste;
		logic [19:0] free_space;
		logic        any_refused;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic eval;
		logic commit;
	} scan_ctl_t;

endpackage

// File: src/fpfa_block_store.sv
// Partition size and waste memories with the per-block taken flags.
module fpfa_block_store import fpfa_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16,
	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scan_ctl_t            ctl,
	input  req_t                 req,
	input  logic [IDX_W-1:0]     rd_addr,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [SIZE_BITS-1:0] wr_waste,
	output logic [SIZE_BITS-1:0] rd_size_s1,
	output logic [SIZE_BITS-1:0] rd_waste_s1,
	output logic                 rd_taken_s1,
	output logic [IDX_W-1:0]     rd_idx_s1
);

	logic [SIZE_BITS-1:0]  size_mem [NUM_BLOCKS];
	logic [SIZE_BITS-1:0]  waste_mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] taken_q;
	logic                  load_en;

	assign load_en = ctl.accept && (req.req_type == REQ_LOAD) &&
		(32'(req.block_slot) < NUM_BLOCKS);

	always_ff @(posedge clk) begin
		if (load_en) begin
			size_mem[IDX_W'(req.block_slot)] <= SIZE_BITS'(req.request_size);
		end
		if (wr_en) begin
			waste_mem[wr_addr] <= wr_waste;
		end
		if (ctl.rd_en) begin
			rd_size_s1  <= size_mem[rd_addr];
			rd_waste_s1 <= waste_mem[rd_addr];
			rd_taken_s1 <= taken_q[rd_addr];
			rd_idx_s1   <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (ctl.accept && (req.req_type == REQ_CLEAR)) begin
			taken_q <= '0;
		end else if (wr_en) begin
			taken_q[wr_addr] <= 1'b1;
		end
	end

endmodule

// File: src/fpfa_scan_unit.sv
// Shared compare and accumulate unit that evaluates one block per cycle.
module fpfa_scan_unit import fpfa_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16,
	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scan_ctl_t            ctl,
	input  req_t                 req,
	input  logic                 fit_mode,
	input  logic [SIZE_BITS-1:0] rd_size_s1,
	input  logic [SIZE_BITS-1:0] rd_waste_s1,
	input  logic                 rd_taken_s1,
	input  logic [IDX_W-1:0]     rd_idx_s1,
	output logic                 wr_en,
	output logic [IDX_W-1:0]     wr_addr,
	output logic [SIZE_BITS-1:0] wr_waste,
	output rsp_t                 rsp
);

	localparam int ACC_W = SIZE_BITS + $clog2(NUM_BLOCKS + 1);
	localparam int SUM_W = (ACC_W > 21) ? ACC_W : 21;

	logic [1:0]           type_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [SUM_W-1:0]     acc_int_q;
	logic [SUM_W-1:0]     acc_free_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [7:0]           proc_cnt_q;
	logic                 refused_q;
	rsp_t                 rsp_q;

	logic                 is_alloc;
	logic                 fits;
	logic                 take;
	logic                 grant;
	logic [SIZE_BITS-1:0] waste_new;
	logic [SUM_W-1:0]     int_sum;
	logic [SUM_W-1:0]     free_sum;
	logic [7:0]           proc_next;
	logic                 refused_next;
	logic [15:0]          frag;

	assign is_alloc = (type_q == REQ_ALLOC);
	assign fits = is_alloc && !rd_taken_s1 && (rd_size_s1 >= size_q);
	assign take = fits && (!found_q || (fit_mode && (rd_size_s1 < best_q)));

	assign grant     = is_alloc && found_q;
	assign waste_new = best_q - size_q;
	assign int_sum   = acc_int_q + (grant ? SUM_W'(waste_new) : '0);
	assign free_sum  = acc_free_q - (grant ? SUM_W'(best_q) : '0);
	assign proc_next = (is_alloc && (proc_cnt_q != PROC_MAX)) ? proc_cnt_q + 8'd1 : proc_cnt_q;
	assign refused_next = refused_q | (is_alloc && !found_q);

	always_comb begin
		if (!grant) begin
			frag = '0;
		end else if (32'(waste_new) > 32'(FRAG_MAX)) begin
			frag = FRAG_MAX;
		end else begin
			frag = 16'(waste_new);
		end
	end

	assign wr_en    = ctl.commit && grant;
	assign wr_addr  = pick_q;
	assign wr_waste = waste_new;

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			type_q     <= req.req_type;
			size_q     <= SIZE_BITS'(req.request_size);
			acc_int_q  <= '0;
			acc_free_q <= '0;
			found_q    <= 1'b0;
		end else if (ctl.eval) begin
			if (rd_taken_s1) begin
				acc_int_q <= acc_int_q + SUM_W'(rd_waste_s1);
			end else begin
				acc_free_q <= acc_free_q + SUM_W'(rd_size_s1);
			end
			if (take) begin
				found_q <= 1'b1;
				pick_q  <= rd_idx_s1;
				best_q  <= rd_size_s1;
			end
		end
		if (ctl.commit) begin
			rsp_q.granted        <= grant;
			rsp_q.placed_block   <= grant ? 4'(pick_q) : 4'd0;
			rsp_q.internal_frag  <= frag;
			rsp_q.process_number <= proc_next;
			rsp_q.total_waste    <= (int_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : int_sum[19:0];
			rsp_q.free_space     <= (free_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : free_sum[19:0];
			rsp_q.any_refused    <= refused_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_cnt_q <= '0;
			refused_q  <= 1'b0;
		end else if (ctl.accept && (req.req_type == REQ_CLEAR)) begin
			proc_cnt_q <= '0;
			refused_q  <= 1'b0;
		end else if (ctl.commit) begin
			proc_cnt_q <= proc_next;
			refused_q  <= refused_next;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: src/fpfa_ctrl.sv
// Sequencer that steps the scan over the blocks in use and commits the result.
module fpfa_ctrl import fpfa_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] n_active,
	output logic             busy,
	output logic             done,
	output scan_ctl_t        ctl,
	output logic [IDX_W-1:0] rd_addr
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] scan_cnt_q;
	logic [CNT_W-1:0] scan_cnt_d;
	logic             eval_s1;
	logic             done_q;
	logic             accept;
	logic             rd_en;
	logic             commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			eval_s1    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			scan_cnt_q <= scan_cnt_d;
			eval_s1    <= rd_en;
			done_q     <= commit;
		end
	end

	always_comb begin
		state_d    = state_q;
		scan_cnt_d = scan_cnt_q;
		accept     = 1'b0;
		rd_en      = 1'b0;
		commit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					accept     = 1'b1;
					scan_cnt_d = '0;
					state_d    = (n_active == '0) ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en      = 1'b1;
				scan_cnt_d = scan_cnt_q + CNT_W'(1);
				if (scan_cnt_q == n_active - CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				commit  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign rd_addr    = scan_cnt_q[IDX_W-1:0];
	assign ctl.accept = accept;
	assign ctl.rd_en  = rd_en;
	assign ctl.eval   = eval_s1;
	assign ctl.commit = commit;

	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_COMMIT))
		else $error("Result strobe without a preceding commit.");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_cnt_q < n_active))
		else $error("Scan index ran past the blocks in use.");

	a_commit_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |=> (done_q && (state_q == ST_IDLE)))
		else $error("Commit did not deliver a result and return to idle.");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("Accepted transaction did not make the block busy.");

endmodule

// File: src/fixed_partition_fit_allocator_core.sv
// Top level of the fixed partition first-fit and best-fit allocator.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req (req_t)
// result    out        done strobe, one cycle    rsp (rsp_t)
// config    in         cfg_valid and cfg_ready   cfg_index, cfg_data
//
// Every request runs from acceptance through a scan that reads one block per cycle from
// the tables, then through the drain and commit states to the done strobe.
// A new request is accepted in the cycle that its predecessor's result is strobed.
// Reset clears taken flags, counters and fit mode, sets 16 blocks in use; sizes stay unknown.
// The result cannot be stalled; configuration writes are always ready.
module fixed_partition_fit_allocator_core import fpfa_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	logic                 fit_mode_q;
	logic [4:0]           blocks_in_use_q;
	logic [CNT_W-1:0]     n_active;
	scan_ctl_t            ctl;
	logic [IDX_W-1:0]     rd_addr;
	logic [SIZE_BITS-1:0] rd_size_s1;
	logic [SIZE_BITS-1:0] rd_waste_s1;
	logic                 rd_taken_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [SIZE_BITS-1:0] wr_waste;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q      <= 1'b0;
			blocks_in_use_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIT_MODE:      fit_mode_q      <= cfg_data[0];
				CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (32'(blocks_in_use_q) > NUM_BLOCKS) begin
			n_active = CNT_W'(NUM_BLOCKS);
		end else begin
			n_active = CNT_W'(blocks_in_use_q);
		end
	end

	fpfa_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.n_active(n_active),
		.busy    (busy),
		.done    (done),
		.ctl     (ctl),
		.rd_addr (rd_addr)
	);

	fpfa_block_store #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.req        (req),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_waste   (wr_waste),
		.rd_size_s1 (rd_size_s1),
		.rd_waste_s1(rd_waste_s1),
		.rd_taken_s1(rd_taken_s1),
		.rd_idx_s1  (rd_idx_s1)
	);

	fpfa_scan_unit #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.req        (req),
		.fit_mode   (fit_mode_q),
		.rd_size_s1 (rd_size_s1),
		.rd_waste_s1(rd_waste_s1),
		.rd_taken_s1(rd_taken_s1),
		.rd_idx_s1  (rd_idx_s1),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_waste   (wr_waste),
		.rsp        (rsp)
	);

endmodule
